// ===== hw/rtl/wyhash64_stream_top_macros.svh =====
// Assertion macros for the wyhash stream block.
// Used by the checker module only.
`ifndef WYHASH64_STREAM_TOP_MACROS_SVH
`define WYHASH64_STREAM_TOP_MACROS_SVH
// implication checked on every rising clock edge outside reset
`define WYH_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("wyh check failed");
// next-cycle implication
`define WYH_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("wyh check failed");
`endif

// ===== hw/rtl/wyh_pkg.sv =====
// Package for the wyhash stream block: secrets and shared types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package wyh_pkg;
  localparam logic [63:0] SECRET0 = 64'h2d358dccaa6c78a5;
  localparam logic [63:0] SECRET1 = 64'h8bb84b93962eacc9;
  localparam logic [63:0] SECRET2 = 64'h4b33a62ed433d4a3;
  localparam logic [63:0] SECRET3 = 64'h4d5a2da51de1aa47;

  typedef struct packed {
    logic [63:0] data_word;
    logic [3:0]  valid_bytes;
    logic        first_word;
    logic        last_word;
    logic [63:0] seed;
  } in_word_t;
endpackage
`default_nettype wire

// ===== hw/rtl/wyh_if.sv =====
// Valid/ready stream interfaces for input words and hash results.
// Depends on wyh_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface wyh_in_if import wyh_pkg::*; ();
  logic     valid;
  logic     ready;
  in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface wyh_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] hash_value;
  modport source (output valid, output hash_value, input ready);
  modport sink (input valid, input hash_value, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/wyh_mul.sv =====
// Shared 64x64->128 multiplier, one 32x32 partial product per cycle.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module wyh_mul (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         start_i,
  input  wire logic [63:0]  a_i,
  input  wire logic [63:0]  b_i,
  output logic              done_o,
  output logic [127:0]      prod_o
);
  logic [63:0]  a_q, b_q;
  logic [2:0]   step_q;
  logic         busy_q;
  logic [127:0] acc_q;
  logic [31:0]  xa, xb;
  logic [63:0]  pp_q;
  logic [2:0]   pstep_q;
  logic         pv_q;
  logic [127:0] shifted;

  // pick partial operands
  always_comb begin
    xa = step_q[1] ? a_q[63:32] : a_q[31:0];
    xb = step_q[0] ? b_q[63:32] : b_q[31:0];
  end

  always_comb begin
    case (pstep_q[1:0])
      2'd0:    shifted = {64'd0, pp_q};
      2'd3:    shifted = {pp_q, 64'd0};
      default: shifted = {32'd0, pp_q, 32'd0};
    endcase
  end

  // partial product register, then accumulate
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; step_q <= '0; pv_q <= 1'b0; pstep_q <= '0; done_o <= 1'b0;
    end else begin
      done_o <= 1'b0;
      pv_q   <= 1'b0;
      if (start_i) begin
        a_q <= a_i; b_q <= b_i; busy_q <= 1'b1; step_q <= '0; acc_q <= '0;
      end else if (busy_q) begin
        pp_q <= xa * xb; pstep_q <= step_q; pv_q <= 1'b1;
        step_q <= step_q + 3'd1;
        if (step_q == 3'd3) busy_q <= 1'b0;
      end
      if (pv_q) begin
        acc_q <= acc_q + shifted;
        if (pstep_q == 3'd3) done_o <= 1'b1;
      end
    end
  end
  assign prod_o = acc_q;
endmodule
`default_nettype wire

// ===== hw/rtl/wyhash64_stream_top.sv =====
// Channel   | dir | payload
// in_s      | in  | data_word, valid_bytes, first_word, last_word, seed
// out_m     | out | hash_value
// Each word is accepted, then stored, before the next is taken. A seed fold, chunk
// fold or finish step waits on the shared multiplier. A 48-byte chunk costs three
// multiplies; a finish costs two to four more, and a first word one more for the seed.
// Reset clears the sequencer, seed, lanes, length and fill, not the chunk buffer or
// recent bytes. A waiting hash stalls only a last word.
// Top level: sequencer around the shared multiplier. Depends on wyh_pkg, wyh_if, wyh_mul.
`timescale 1ns / 1ps
`default_nettype none
module wyhash64_stream_top import wyh_pkg::*; #(
  parameter int LENGTH_BITS = 32
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  wyh_in_if.sink    in_s,
  wyh_out_if.source out_m
);
  typedef enum logic [3:0] {
    S_IDLE, S_SEED, S_STORE, S_C0, S_C1, S_C2, S_FIN, S_LOOP, S_M1, S_M2, S_OUT
  } state_e;

  state_e      state_q;
  in_word_t    w_q;
  logic [63:0] seed_q, l1_q, l2_q, sacc_q, fa_q, fb_q;
  logic [63:0] buf_q [6];
  logic [127:0] recent_q;
  logic [LENGTH_BITS-1:0] cnt_q;
  logic [5:0]  fill_q, n_q, pos_q;
  logic        wide_q, first_q, mgo_q;
  logic        mgo_d;
  logic        mstart;
  logic [63:0] ma, mb;
  logic        mdone;
  logic [127:0] prod;
  logic [63:0] fold;
  logic [3:0]  nb;
  logic [63:0] mword;
  logic [127:0] recent_new;
  logic [63:0] sa, sb;
  logic [3:0]  q;
  logic [383:0] flat;

  wyh_mul u_mul (.clk_i, .rst_ni, .start_i(mstart), .a_i(ma), .b_i(mb),
                 .done_o(mdone), .prod_o(prod));
  assign fold = prod[63:0] ^ prod[127:64];

  // byte helpers over the chunk buffer
  function automatic logic [7:0] bb(input logic [383:0] f, input logic [5:0] i);
    bb = f[{i, 3'b000} +: 8];
  endfunction
  function automatic logic [31:0] r4(input logic [383:0] f, input logic [5:0] o);
    r4 = {bb(f, o + 6'd3), bb(f, o + 6'd2), bb(f, o + 6'd1), bb(f, o)};
  endfunction

  always_comb begin
    for (int k = 0; k < 6; k++) flat[k*64 +: 64] = buf_q[k];
  end

  // word masking and recent-bytes shift
  always_comb begin
    nb = w_q.last_word ? ((w_q.valid_bytes > 4'd8) ? 4'd8 : w_q.valid_bytes) : 4'd8;
    mword = (nb == 4'd0) ? 64'd0 : (w_q.data_word & (~64'd0 >> (7'd64 - {nb, 3'b000})));
    recent_new = (recent_q >> {nb, 3'b000}) | ({64'd0, mword} << (8'd128 - {nb, 6'b0} / 8));
  end

  // short path gather
  always_comb begin
    q = {n_q[4:3], 2'b00};
    if (n_q >= 6'd4) begin
      sa = {r4(flat, 6'd0), r4(flat, {2'd0, q})};
      sb = {r4(flat, n_q - 6'd4), r4(flat, n_q - 6'd4 - {2'd0, q})};
    end else if (n_q != 6'd0) begin
      sa = {40'd0, bb(flat, 6'd0), bb(flat, {1'b0, n_q[5:1]}), bb(flat, n_q - 6'd1)};
      sb = '0;
    end else begin
      sa = '0; sb = '0;
    end
  end

  assign in_s.ready = (state_q == S_IDLE) && !(out_m.valid && in_s.data.last_word);

  // multiplier start, registered together with its operands
  always_comb begin
    mgo_d = 1'b0;
    case (state_q)
      S_IDLE:  mgo_d = in_s.valid && in_s.ready && in_s.data.first_word;
      S_STORE: mgo_d = (nb != 4'd0) && (fill_q + {2'd0, nb} >= 6'd48);
      S_C0:    mgo_d = mdone;
      S_C1:    mgo_d = mdone;
      S_FIN:   mgo_d = !wide_q && n_q <= 6'd16;
      S_LOOP:  mgo_d = first_q;
      S_M1:    mgo_d = mdone;
      default: mgo_d = 1'b0;
    endcase
  end

  always_comb begin
    mstart = mgo_q; ma = fa_q; mb = fb_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; seed_q <= '0; l1_q <= '0; l2_q <= '0; cnt_q <= '0;
      fill_q <= '0; wide_q <= 1'b0; mgo_q <= 1'b0; out_m.valid <= 1'b0;
      first_q <= 1'b0;
    end else begin
      if (out_m.valid && out_m.ready) out_m.valid <= 1'b0;
      mgo_q <= mgo_d;
      case (state_q)
        S_IDLE: if (in_s.valid && in_s.ready) begin
          w_q <= in_s.data;
          if (in_s.data.first_word) begin
            fa_q <= in_s.data.seed ^ SECRET0; fb_q <= SECRET1; state_q <= S_SEED;
            seed_q <= '0; l1_q <= '0; l2_q <= '0; cnt_q <= '0; fill_q <= '0;
            wide_q <= 1'b0;
          end else state_q <= S_STORE;
        end
        S_SEED: if (mdone) begin
          seed_q <= w_q.seed ^ fold; state_q <= S_STORE;
        end
        S_STORE: begin
          if (nb != 4'd0) begin
            buf_q[fill_q[5:3]] <= mword;
            cnt_q <= cnt_q + LENGTH_BITS'(nb);
            recent_q <= recent_new;
            fill_q <= fill_q + {2'd0, nb};
          end
          if (nb != 4'd0 && fill_q + {2'd0, nb} >= 6'd48) begin
            if (!wide_q) begin l1_q <= seed_q; l2_q <= seed_q; end
            wide_q <= 1'b1;
            fa_q <= buf_q[0] ^ SECRET1; fb_q <= buf_q[1] ^ seed_q;
            state_q <= S_C0;
          end else if (w_q.last_word) begin
            n_q <= fill_q + {2'd0, nb}; pos_q <= '0; sacc_q <= seed_q;
            state_q <= S_FIN;
          end else state_q <= S_IDLE;
        end
        // fill==48 only arises with a word landing in buf[5]; buf[1] is already set
        S_C0: if (mdone) begin
          seed_q <= fold; fa_q <= buf_q[2] ^ SECRET2; fb_q <= buf_q[3] ^ l1_q;
          state_q <= S_C1;
        end
        S_C1: if (mdone) begin
          l1_q <= fold; fa_q <= buf_q[4] ^ SECRET3; fb_q <= buf_q[5] ^ l2_q;
          state_q <= S_C2;
        end
        S_C2: if (mdone) begin
          l2_q <= fold; fill_q <= '0;
          if (w_q.last_word) begin
            n_q <= '0; pos_q <= '0; sacc_q <= seed_q; state_q <= S_FIN;
          end else state_q <= S_IDLE;
        end
        S_FIN: begin
          // decide path: short gathers or the 16-byte loop
          if (!wide_q && n_q <= 6'd16) begin
            fa_q <= sa ^ SECRET1; fb_q <= sb ^ sacc_q; state_q <= S_M1;
          end else begin
            if (wide_q) sacc_q <= sacc_q ^ l1_q ^ l2_q;
            state_q <= S_LOOP; first_q <= 1'b1;
          end
        end
        S_LOOP: begin
          if (first_q) begin
            first_q <= 1'b0;
            if (n_q <= 6'd16) begin
              fa_q <= recent_q[63:0] ^ SECRET1; fb_q <= recent_q[127:64] ^ sacc_q;
              state_q <= S_M1;
            end else begin
              fa_q <= buf_q[pos_q[5:3]] ^ SECRET1;
              fb_q <= buf_q[(pos_q[5:3] == 3'd5) ? 3'd0 : pos_q[5:3] + 3'd1] ^ sacc_q;
            end
          end else if (mdone) begin
            sacc_q <= fold; n_q <= n_q - 6'd16; pos_q <= pos_q + 6'd16; first_q <= 1'b1;
          end
        end
        S_M1: if (mdone) begin
          fa_q <= prod[63:0] ^ SECRET0 ^ 64'(cnt_q); fb_q <= prod[127:64] ^ SECRET1;
          state_q <= S_M2;
        end
        S_M2: if (mdone) begin
          out_m.hash_value <= fold; out_m.valid <= 1'b1; state_q <= S_IDLE;
          seed_q <= '0; l1_q <= '0; l2_q <= '0; cnt_q <= '0; fill_q <= '0;
          wide_q <= 1'b0;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== hw/rtl/wyh_checker.sv =====
// Port-level checker for the wyhash stream top, with its bind.
// Depends on the macros header and wyh_if.
`timescale 1ns / 1ps
`default_nettype none
`include "wyhash64_stream_top_macros.svh"
module wyh_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_i,
  input wire logic        in_last_i,
  input wire logic        out_valid_i,
  input wire logic        out_ready_i,
  input wire logic [63:0] out_hash_i
);
  // a last word is never taken while a hash still waits
  `WYH_ASSERT_IMP(a_no_overrun, clk_i, rst_ni, out_valid_i && in_last_i, !in_ready_i)
  // no word is taken in the cycle after a last word
  `WYH_ASSERT_NXT(a_no_take_after_last, clk_i, rst_ni,
    in_valid_i && in_ready_i && in_last_i, !in_ready_i)
  // a stalled hash holds
  `WYH_ASSERT_NXT(a_hold, clk_i, rst_ni, out_valid_i && !out_ready_i,
    out_valid_i && $stable(out_hash_i))
endmodule

bind wyhash64_stream_top wyh_checker u_chk (
  .clk_i(clk_i), .rst_ni(rst_ni), .in_valid_i(in_s.valid), .in_ready_i(in_s.ready),
  .in_last_i(in_s.data.last_word), .out_valid_i(out_m.valid),
  .out_ready_i(out_m.ready), .out_hash_i(out_m.hash_value)
);
`default_nettype wire
